// ----- rtl/bfp_pkg.sv -----
// Shared types, codes and default sizes for the bin-fit placement block.
// No dependencies; used by bfp_alu and bin_fit_placement_top.
`default_nettype none
package bfp_pkg;

  // Field widths fixed by the external interface
  localparam int CMD_W      = 1;
  localparam int IDX_PORT_W = 10;
  localparam int AMT_W      = 23;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // Default sizing
  localparam int MAX_BUCKETS_DEF = 1024;
  localparam int SPACE_BITS_DEF  = 23;

  // Register reset values
  localparam logic [MODE_W-1:0]  MODE_RST  = 2'd0;
  localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_PLACE = 1'b1;

  // Placement policies
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // Compare unit result
  typedef struct packed {
    logic fit;   // bucket space >= ball size
    logic take;  // bucket replaces current pick
  } cmp_res_t;

endpackage
`default_nettype wire

// ----- rtl/bfp_mem.sv -----
// Bucket space memory: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none
module bfp_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 23
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/bfp_alu.sv -----
// Shared compare/subtract unit: fit test, policy ranking, space update.
// Depends on bfp_pkg.
`default_nettype none
module bfp_alu #(
  parameter int SPACE_BITS = bfp_pkg::SPACE_BITS_DEF
) (
  input  wire logic [bfp_pkg::MODE_W-1:0] mode,
  input  wire logic                       found,
  input  wire logic [SPACE_BITS-1:0]      space,
  input  wire logic [SPACE_BITS-1:0]      amt,
  input  wire logic [SPACE_BITS-1:0]      best,
  output bfp_pkg::cmp_res_t               res,
  output logic      [SPACE_BITS-1:0]      diff
);

  logic fit;
  logic take;

  assign fit = (space >= amt);

  always_comb begin
    case (mode)
      bfp_pkg::MODE_FIRST: take = fit;
      bfp_pkg::MODE_BEST:  take = fit && (!found || (space < best));
      bfp_pkg::MODE_WORST: take = fit && (!found || (space >= best));
      default:             take = 1'b0;
    endcase
  end

  assign res.fit  = fit;
  assign res.take = take;

  // remaining space of the chosen bucket
  assign diff = best - amt;

endmodule
`default_nettype wire

// ----- rtl/bin_fit_placement_top.sv -----
// Bin-fit placement: a load beat is taken in idle without a stall; a place beat
// stalls the input through the scan of the n buckets in use (a first-fit hit ends it,
// n of 0 skips it), the space update and the report, and while an earlier result
// sits stalled at the output. Pace is set by the single memory read port: one bucket
// read per cycle; the result is registered from the report state as the stall drops.
// Sync active-low reset: control idle, mode first fit, count 1024; memory not cleared.
`default_nettype none
module bin_fit_placement_top #(
  parameter int MAX_BUCKETS = bfp_pkg::MAX_BUCKETS_DEF,
  parameter int SPACE_BITS  = bfp_pkg::SPACE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bfp_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [bfp_pkg::IDX_PORT_W-1:0] in_bucket_index,
  input  wire logic [bfp_pkg::AMT_W-1:0]      in_amount,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_placed,
  output logic      [bfp_pkg::IDX_PORT_W-1:0] out_chosen_bucket,
  // configuration port
  input  wire logic                           cfg_wr_en,
  input  wire logic [bfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bfp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_BUCKETS);
  localparam int CNT_W = $clog2(MAX_BUCKETS + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;  // stream buckets through the compare unit
  localparam logic [1:0] ST_UPDATE = 2'd2;  // write back reduced space of the pick
  localparam logic [1:0] ST_REPORT = 2'd3;  // hand result to the output register

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bfp_pkg::MODE_W-1:0]  mode_r;
  logic [bfp_pkg::COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= bfp_pkg::MODE_RST;
      count_r <= bfp_pkg::COUNT_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == bfp_pkg::REG_MODE) begin
        mode_r <= cfg_wdata[bfp_pkg::MODE_W-1:0];
      end else if (cfg_index == bfp_pkg::REG_COUNT) begin
        count_r <= cfg_wdata[bfp_pkg::COUNT_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [1:0]            state_r,    state_nxt;
  logic [CNT_W-1:0]      n_r,        n_nxt;       // buckets to scan
  logic [CNT_W-1:0]      rd_idx_r,   rd_idx_nxt;  // next read address
  logic                  rsp_vld_r,  rsp_vld_nxt; // read data valid this cycle
  logic                  rsp_last_r, rsp_last_nxt;
  logic [IDX_W-1:0]      rsp_idx_r,  rsp_idx_nxt;
  logic                  found_r,    found_nxt;
  logic [IDX_W-1:0]      pick_r,     pick_nxt;
  logic [SPACE_BITS-1:0] best_r,     best_nxt;    // space of current pick
  logic [SPACE_BITS-1:0] amt_r,      amt_nxt;

  // output register
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_placed_r, out_placed_nxt;
  logic [bfp_pkg::IDX_PORT_W-1:0] out_chosen_r, out_chosen_nxt;

  // datapath helpers
  logic                  in_acc;
  logic [31:0]           amt_ext;
  logic [31:0]           idx_ext;
  logic [31:0]           cnt_ext;
  logic [31:0]           n_sel;
  logic [31:0]           pick_ext;
  logic                  load_ok;
  logic                  issue;
  logic                  stop;
  logic [CNT_W-1:0]      rd_idx_inc;
  logic                  out_free;

  // memory and compare unit
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [SPACE_BITS-1:0] mem_wdata;
  logic [SPACE_BITS-1:0] mem_rdata;
  bfp_pkg::cmp_res_t     cmp_res;
  logic [SPACE_BITS-1:0] alu_diff;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign amt_ext  = 32'(in_amount);
  assign idx_ext  = 32'(in_bucket_index);
  assign cnt_ext  = 32'(count_r);
  // bucket_count saturates at the table depth
  assign n_sel    = (cnt_ext > 32'(MAX_BUCKETS)) ? 32'(MAX_BUCKETS) : cnt_ext;
  assign load_ok  = (idx_ext < 32'(MAX_BUCKETS));
  assign pick_ext = 32'(pick_r);

  assign rd_idx_inc = rd_idx_r + CNT_W'(1);
  assign issue      = (state_r == ST_SCAN) && (rd_idx_r < n_r);
  // first fit quits on the first hit; others run to the last bucket
  assign stop       = rsp_vld_r &&
                      (rsp_last_r || ((mode_r == bfp_pkg::MODE_FIRST) && cmp_res.fit));
  assign out_free   = !(out_valid_r && out_stall);

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    rd_idx_nxt     = rd_idx_r;
    rsp_vld_nxt    = 1'b0;
    rsp_last_nxt   = rsp_last_r;
    rsp_idx_nxt    = rsp_idx_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    best_nxt       = best_r;
    amt_nxt        = amt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_placed_nxt = out_placed_r;
    out_chosen_nxt = out_chosen_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == bfp_pkg::CMD_PLACE)) begin
          amt_nxt    = amt_ext[SPACE_BITS-1:0];
          n_nxt      = n_sel[CNT_W-1:0];
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          state_nxt  = (n_sel == 32'd0) ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_nxt   = rd_idx_inc;
          rsp_vld_nxt  = !stop;
          rsp_last_nxt = (rd_idx_inc == n_r);
          rsp_idx_nxt  = rd_idx_r[IDX_W-1:0];
        end
        if (rsp_vld_r && cmp_res.take) begin
          found_nxt = 1'b1;
          pick_nxt  = rsp_idx_r;
          best_nxt  = mem_rdata;
        end
        if (stop) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_placed_nxt = found_r;
          out_chosen_nxt = found_r ? pick_ext[bfp_pkg::IDX_PORT_W-1:0] : '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rsp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rsp_vld_r   <= rsp_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    rd_idx_r     <= rd_idx_nxt;
    rsp_last_r   <= rsp_last_nxt;
    rsp_idx_r    <= rsp_idx_nxt;
    pick_r       <= pick_nxt;
    best_r       <= best_nxt;
    amt_r        <= amt_nxt;
    out_placed_r <= out_placed_nxt;
    out_chosen_r <= out_chosen_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_placed        = out_placed_r;
  assign out_chosen_bucket = out_chosen_r;

  // ---------------------------------------------------------------------------
  // Memory write port: load beats in idle, space update after a scan
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_ext[IDX_W-1:0];
    mem_wdata = amt_ext[SPACE_BITS-1:0];
    if (state_r == ST_UPDATE) begin
      mem_we    = found_r;
      mem_waddr = pick_r;
      mem_wdata = alu_diff;
    end else if (in_acc && (in_cmd == bfp_pkg::CMD_LOAD)) begin
      mem_we = load_ok;  // out-of-range loads are dropped
    end
  end

  bfp_mem #(
    .DEPTH  (MAX_BUCKETS),
    .ADDR_W (IDX_W),
    .DATA_W (SPACE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  bfp_alu #(
    .SPACE_BITS (SPACE_BITS)
  ) u_alu (
    .mode  (mode_r),
    .found (found_r),
    .space (mem_rdata),
    .amt   (amt_r),
    .best  (best_r),
    .res   (cmp_res),
    .diff  (alu_diff)
  );

`ifndef SYNTHESIS
  // a pick always lies inside the scanned range
  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && found_r) |-> (pick_ext < 32'(n_r)))
    else $error("pick outside scanned range");

  // read pointer never runs past the bucket count
  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_idx_r <= n_r))
    else $error("scan read pointer overran");

  // memory is written only by loads in idle or the post-scan update
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_IDLE || state_r == ST_UPDATE))
    else $error("unexpected memory write");

  // a no-fit result reports bucket zero
  a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_placed_r) |-> (out_chosen_r == '0))
    else $error("no-fit result with nonzero bucket");
`endif

endmodule
`default_nettype wire

// ----- tb/bin_fit_placement_top_test.sv -----
// Self-checking testbench for bin_fit_placement_top: loads bucket capacities, places
// balls under every policy and a range of bucket counts, and checks each result beat.
// Depends on rtl/bfp_pkg.sv and rtl/bin_fit_placement_top.sv.
module bin_fit_placement_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BUCKETS = bfp_pkg::MAX_BUCKETS_DEF;
  localparam int SPACE_W     = bfp_pkg::SPACE_BITS_DEF;
  // Buckets loaded up front; counts past this only run first fit with balls
  // that land inside this range, so no scan reads an unloaded bucket.
  localparam int LOADED      = 64;
  // Longest stretch with no beat on any port; a full 1024-bucket scan, plus gaps
  // and stalls, stays well inside it, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 12000;
  // Cycles to let a trailing load settle before touching the registers.
  localparam int SETTLE_CYCLES = 8;

  typedef logic [bfp_pkg::AMT_W-1:0]      amount_t;
  typedef logic [bfp_pkg::IDX_PORT_W-1:0] bucket_t;
  typedef logic [bfp_pkg::MODE_W-1:0]     mode_t;
  typedef logic [bfp_pkg::CFG_DATA_W-1:0] cfg_data_t;

  // Codes the package leaves unnamed.
  localparam logic [bfp_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [bfp_pkg::CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

  localparam amount_t AMT_MAX = {bfp_pkg::AMT_W{1'b1}};

  typedef struct packed {
    logic    placed;
    bucket_t chosen_bucket;
  } placement_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [bfp_pkg::CMD_W-1:0]        in_cmd;
  logic [bfp_pkg::IDX_PORT_W-1:0]   in_bucket_index;
  logic [bfp_pkg::AMT_W-1:0]        in_amount;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_placed;
  logic [bfp_pkg::IDX_PORT_W-1:0]   out_chosen_bucket;
  logic                             cfg_wr_en;
  logic [bfp_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [bfp_pkg::CFG_DATA_W-1:0]   cfg_wdata;

  // Mirror of the block's state: free space per bucket and both registers.
  logic [SPACE_W-1:0]               space_mirror [NUM_BUCKETS];
  logic [bfp_pkg::MODE_W-1:0]       mode_mirror;
  logic [bfp_pkg::COUNT_W-1:0]      count_mirror;

  placement_t expected_placements[$];
  int         errors = 0;
  bit         calm = 1'b0;   // when set, neither side idles
  int         out_hold = 0;
  int         quiet_cycles = 0;

  bin_fit_placement_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_bucket_index   (in_bucket_index),
    .in_amount         (in_amount),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_placed        (out_placed),
    .out_chosen_bucket (out_chosen_bucket),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Placement predictor: scans buckets 0..n-1 (count saturated at the table
  // size) under the mirrored policy, debits the pick and returns the result.
  // ---------------------------------------------------------------------------
  function automatic placement_t predict_placement(amount_t ball);
    placement_t         res;
    int                 n;
    int                 pick;
    logic [SPACE_W-1:0] pick_space;
    bit                 found;
    res        = '0;
    pick       = 0;
    pick_space = '0;
    found      = 1'b0;
    n = (count_mirror > NUM_BUCKETS) ? NUM_BUCKETS : int'(count_mirror);
    for (int j = 0; j < n; j++) begin
      if (space_mirror[j] >= ball) begin
        case (mode_mirror)
          bfp_pkg::MODE_FIRST: begin
            if (!found) begin
              found = 1'b1;
              pick  = j;
            end
          end
          bfp_pkg::MODE_BEST: begin
            // strict compare keeps the lowest index on ties
            if (!found || space_mirror[j] < pick_space) begin
              found      = 1'b1;
              pick       = j;
              pick_space = space_mirror[j];
            end
          end
          bfp_pkg::MODE_WORST: begin
            // >= moves ties to the highest index
            if (!found || space_mirror[j] >= pick_space) begin
              found      = 1'b1;
              pick       = j;
              pick_space = space_mirror[j];
            end
          end
          default: ;  // unused policy places nothing
        endcase
      end
    end
    if (found) begin
      space_mirror[pick] = space_mirror[pick] - ball;
      res.placed         = 1'b1;
      res.chosen_bucket  = pick[bfp_pkg::IDX_PORT_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one beat per call, with a random lead-in gap. Returns at the
  // edge where the beat was taken, valid still high.
  // ---------------------------------------------------------------------------
  task automatic send_beat(logic [bfp_pkg::CMD_W-1:0] cmd, bucket_t idx, amount_t amt);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_bucket_index <= idx;
    in_amount       <= amt;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (cmd == bfp_pkg::CMD_LOAD)
      space_mirror[idx] = amt;
    else
      expected_placements.push_back(predict_placement(amt));
  endtask

  task automatic load_bucket(int idx, amount_t cap);
    send_beat(bfp_pkg::CMD_LOAD, idx[bfp_pkg::IDX_PORT_W-1:0], cap);
  endtask

  // Bucket field is don't-care on a place; drive junk so it gets exercised.
  task automatic place_ball(amount_t ball);
    send_beat(bfp_pkg::CMD_PLACE, bucket_t'($urandom), ball);
  endtask

  // Drop valid, drain all outstanding results, then let a trailing load settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(logic [bfp_pkg::CFG_IDX_W-1:0] idx, cfg_data_t val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == bfp_pkg::REG_MODE)
      mode_mirror = val[bfp_pkg::MODE_W-1:0];
    else if (idx == bfp_pkg::REG_COUNT)
      count_mirror = val;
  endtask

  // Mode write with random upper bits, then a count write; only the low two bits of the mode should count.
  task automatic set_policy(mode_t mode, int count);
    cfg_data_t val;
    wait_idle();
    val = cfg_data_t'($urandom);
    val[bfp_pkg::MODE_W-1:0] = mode;
    write_reg(bfp_pkg::REG_MODE, val);
    write_reg(bfp_pkg::REG_COUNT, count[bfp_pkg::CFG_DATA_W-1:0]);
  endtask

  function automatic amount_t random_capacity();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return amount_t'($urandom_range(0, 15));  // dense, many ties
      4, 5, 6:    return amount_t'($urandom);
      7:          return AMT_MAX;
      8:          return '0;
      default:    return amount_t'($urandom_range(0, 1023));
    endcase
  endfunction

  // Ball sizes aimed at the current free space so that fits, exact fits and
  // near misses all come up.
  function automatic amount_t random_ball(int n);
    int j;
    j = (n > 0) ? $urandom_range(0, n - 1) : 0;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return AMT_MAX;
      2, 3:    return space_mirror[j];
      4:       return space_mirror[j] + 1'b1;
      5:       return amount_t'($urandom_range(0, 15));
      6:       return amount_t'($urandom);
      default: return space_mirror[j] - amount_t'($urandom_range(0, 3));
    endcase
  endfunction

  // A ball that some loaded bucket can take, so a first-fit scan ends inside
  // the loaded range even when the count reaches past it.
  function automatic amount_t safe_ball();
    int      j;
    amount_t r;
    j = $urandom_range(0, LOADED - 1);
    r = amount_t'($urandom_range(0, 3));
    return (space_mirror[j] >= r) ? space_mirror[j] - r : '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Load the low buckets, then place under the reset defaults (first fit over
  // a count of 1024). Two full buckets at the top of the loaded range make
  // every ball here land before the scan leaves it.
  task automatic test_table_fill_defaults();
    for (int i = 0; i < LOADED; i++) begin
      if (i == 0)
        load_bucket(i, '0);
      else if (i >= LOADED - 2)
        load_bucket(i, AMT_MAX);
      else
        load_bucket(i, random_capacity());
    end
    place_ball(AMT_MAX);    // deep in the loaded range
    place_ball('0);         // zero ball fits the empty bucket 0
    place_ball(amount_t'(5));
  endtask

  task automatic test_first_fit();
    set_policy(bfp_pkg::MODE_FIRST, 4);
    load_bucket(0, amount_t'(3));
    load_bucket(1, amount_t'(10));
    load_bucket(2, amount_t'(10));
    load_bucket(3, AMT_MAX);
    place_ball(amount_t'(5));
    place_ball(amount_t'(8));
    place_ball(AMT_MAX);    // only the full bucket fits, exactly
    place_ball('0);
    place_ball(amount_t'(11)); // no fit
  endtask

  task automatic test_best_fit();
    set_policy(bfp_pkg::MODE_BEST, 4);
    load_bucket(0, amount_t'(6));
    load_bucket(1, amount_t'(4));
    load_bucket(2, amount_t'(4));
    load_bucket(3, amount_t'(9));
    place_ball(amount_t'(4));  // tie, lowest index wins
    place_ball(amount_t'(4));
    place_ball(amount_t'(7));
    place_ball('0);            // drained buckets still take a zero ball
    place_ball(amount_t'(10));
  endtask

  task automatic test_worst_fit();
    set_policy(bfp_pkg::MODE_WORST, 4);
    load_bucket(0, amount_t'(9));
    load_bucket(1, amount_t'(5));
    load_bucket(2, amount_t'(9));
    load_bucket(3, amount_t'(1));
    place_ball(amount_t'(1));  // tie, highest index wins
    place_ball(amount_t'(1));
    place_ball(amount_t'(8));
    place_ball(amount_t'(9));
  endtask

  // Unused policy, a write to a non-register index, count of zero, one, and
  // counts at and beyond the table size.
  task automatic test_mode_and_count_edges();
    set_policy(MODE_UNUSED, 4);
    place_ball('0);
    wait_idle();
    write_reg(REG_SPARE, {bfp_pkg::CFG_DATA_W{1'b1}});  // must not disturb anything
    place_ball(amount_t'(1));
    set_policy(bfp_pkg::MODE_FIRST, 0);
    place_ball('0);
    set_policy(bfp_pkg::MODE_BEST, 1);
    place_ball('0);
    set_policy(bfp_pkg::MODE_FIRST, {bfp_pkg::COUNT_W{1'b1}});  // saturates
    place_ball(safe_ball());
    set_policy(bfp_pkg::MODE_FIRST, NUM_BUCKETS);
    place_ball(safe_ball());
  endtask

  // Phases with random policy and bucket count, each a random mix of loads
  // and places. Big counts are rare and run first fit with balls that land
  // inside the loaded range.
  task automatic test_random_mix(int total_beats);
    int    sent;
    int    beats;
    int    count;
    int    n;
    mode_t mode;
    bit    big;
    sent = 0;
    while (sent < total_beats) begin
      big = ($urandom_range(0, 11) == 0);
      if (big)
        mode = bfp_pkg::MODE_FIRST;
      else
        mode = ($urandom_range(0, 7) == 0) ? MODE_UNUSED : mode_t'($urandom_range(0, 2));
      case ($urandom_range(0, 19))
        0:       count = 0;
        1, 2:    count = $urandom_range(17, LOADED);
        default: count = $urandom_range(1, 16);
      endcase
      if (big)
        count = $urandom_range(NUM_BUCKETS, (1 << bfp_pkg::COUNT_W) - 1);
      beats = big ? $urandom_range(6, 10) : $urandom_range(15, 35);
      calm  = ($urandom_range(0, 3) == 0);
      set_policy(mode, count);
      n = (count > NUM_BUCKETS) ? NUM_BUCKETS : count;
      for (int b = 0; b < beats; b++) begin
        if ($urandom_range(0, 99) < 40) begin
          if (n > 0 && $urandom_range(0, 3) != 0)
            load_bucket($urandom_range(0, n - 1), random_capacity());
          else
            load_bucket($urandom_range(0, NUM_BUCKETS - 1), random_capacity());
        end else begin
          place_ball(big ? safe_ball() : random_ball(n));
        end
      end
      sent += beats;
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and output back-pressure. After each taken result beat a
  // fresh random stall length is drawn (none when calm); it runs down while a
  // result waits.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    placement_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_placements.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected: placed=%0d bucket=%0d",
                 $time, out_placed, out_chosen_bucket);
      end else begin
        want = expected_placements.pop_front();
        if (out_placed !== want.placed) begin
          errors++;
          $display("%0t: placed expected %0d actual %0d", $time, want.placed, out_placed);
        end
        if (out_chosen_bucket !== want.chosen_bucket) begin
          errors++;
          $display("%0t: chosen_bucket expected %0d actual %0d",
                   $time, want.chosen_bucket, out_chosen_bucket);
        end
      end
      out_hold = calm ? 0 : $urandom_range(0, 3);
    end else if (out_valid && out_hold > 0) begin
      out_hold--;
    end
    out_stall <= (out_hold != 0);
  end

  // Watchdog: any beat on the input, result or register port counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles at %0t", QUIET_LIMIT, $time);
        $display("bin_fit_placement_top_test: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_cmd          = bfp_pkg::CMD_LOAD;
    in_bucket_index = '0;
    in_amount       = '0;
    cfg_wr_en       = 1'b0;
    cfg_index       = bfp_pkg::REG_MODE;
    cfg_wdata       = '0;
    mode_mirror     = bfp_pkg::MODE_RST;
    count_mirror    = bfp_pkg::COUNT_RST;
    for (int i = 0; i < NUM_BUCKETS; i++) space_mirror[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_table_fill_defaults();
    test_first_fit();
    test_best_fit();
    test_worst_fit();
    test_mode_and_count_edges();
    test_random_mix(480);

    wait_idle();
    if (errors == 0)
      $display("bin_fit_placement_top_test: clean");
    else
      $display("bin_fit_placement_top_test: errors");
    $finish;
  end

endmodule
